FILE: sv/isq_pkg.sv
// ----------------------------------------------------------------------------
// Indexed sequence store package
// Widths, operation and status codes, and the command that runs along the
// row of storage cells.
// ----------------------------------------------------------------------------
package isq_pkg;

    localparam int CAPACITY = 64;
    localparam int IDX_W    = $clog2(CAPACITY);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int KIND_W   = 3;
    localparam int POS_W    = 10;
    localparam int VAL_W    = 32;
    localparam int ST_W     = 2;
    localparam int LEN_W    = 7;
    localparam int CMP_W    = (POS_W > CNT_W) ? POS_W + 1 : CNT_W + 1;

    typedef enum logic [KIND_W-1:0] {
        KIND_READ   = 3'd0,
        KIND_HEAD   = 3'd1,
        KIND_TAIL   = 3'd2,
        KIND_AT     = 3'd3,
        KIND_DELETE = 3'd4
    } kind_t;

    typedef enum logic [ST_W-1:0] {
        ST_DONE  = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        ACT_NONE,
        ACT_READ,
        ACT_INSERT,
        ACT_DELETE
    } act_t;

    typedef enum logic {
        S_IDLE,
        S_GATHER
    } state_t;

    typedef struct packed {
        act_t             act;
        logic [IDX_W-1:0] pos;
        logic [VAL_W-1:0] value;
    } cell_cmd_t;

endpackage

FILE: sv/indexed_sequence_store.sv
// ----------------------------------------------------------------------------
// Indexed sequence store
// An ordered sequence of up to CAPACITY signed words kept in a row of cells
// that shift together on insert and delete, with a read by position.
// ----------------------------------------------------------------------------
//  Channel   Handshake            Payload
//  input     in_valid/in_ready    kind, position, value
//  output    out_valid/out_ready  read_value, status, length
//
// A request is handled alone: the cells shift or capture in the cycle of
// acceptance, and the next cycle merges the captured read words into the
// output register. A new request is taken once that register is free or is
// being emptied in the same cycle. Reset clears the count and control state,
// not the entries or the output payload. A stalled output holds back the input.
// ----------------------------------------------------------------------------
module indexed_sequence_store (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [isq_pkg::KIND_W-1:0]        kind,
    input  logic [isq_pkg::POS_W-1:0]         position,
    input  logic signed [isq_pkg::VAL_W-1:0]  value,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [isq_pkg::VAL_W-1:0]  read_value,
    output logic [isq_pkg::ST_W-1:0]          status,
    output logic [isq_pkg::LEN_W-1:0]         length
);
    import isq_pkg::*;

    state_t           state_reg;
    state_t           state_next;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             out_valid_reg;
    logic             out_valid_next;
    status_t          st_pend_reg;
    status_t          st_pend_next;
    logic             rd_ok_reg;
    logic             rd_ok_next;
    logic [VAL_W-1:0] read_value_reg;
    logic [VAL_W-1:0] read_value_next;
    status_t          status_reg;
    status_t          status_next;
    logic [LEN_W-1:0] length_reg;
    logic [LEN_W-1:0] length_next;

    logic             accept;
    cell_cmd_t        cmd;
    logic [CMP_W-1:0] pos_x;
    logic [CMP_W-1:0] cnt_x;
    logic [CMP_W-1:0] at_x;
    logic             full;
    logic [VAL_W-1:0] rd_all;

    logic [VAL_W-1:0] entry_w [CAPACITY];
    logic [VAL_W-1:0] rd_w    [CAPACITY];

    assign in_ready = (state_reg == S_IDLE) && (!out_valid_reg || out_ready);
    assign accept   = in_valid && in_ready;
    assign pos_x    = CMP_W'(position);
    assign cnt_x    = CMP_W'(count_reg);
    assign full     = (count_reg == CNT_W'(CAPACITY));

    always_comb
    begin
        at_x         = pos_x;
        cmd.act      = ACT_NONE;
        cmd.pos      = position[IDX_W-1:0];
        cmd.value    = value;
        count_next   = count_reg;
        st_pend_next = st_pend_reg;
        rd_ok_next   = rd_ok_reg;
        if (kind == KIND_HEAD)
        begin
            at_x = '0;
        end
        else if (kind == KIND_TAIL)
        begin
            at_x = cnt_x;
        end
        if (accept)
        begin
            st_pend_next = ST_DONE;
            rd_ok_next   = 1'b0;
            case (kind_t'(kind))
                KIND_READ:
                begin
                    if (pos_x < cnt_x)
                    begin
                        cmd.act    = ACT_READ;
                        rd_ok_next = 1'b1;
                    end
                    else
                    begin
                        st_pend_next = ST_RANGE;
                    end
                end
                KIND_HEAD, KIND_TAIL, KIND_AT:
                begin
                    if (at_x > cnt_x)
                    begin
                        st_pend_next = ST_RANGE;
                    end
                    else if (full)
                    begin
                        st_pend_next = ST_FULL;
                    end
                    else
                    begin
                        cmd.act    = ACT_INSERT;
                        cmd.pos    = at_x[IDX_W-1:0];
                        count_next = count_reg + 1'b1;
                    end
                end
                KIND_DELETE:
                begin
                    if (pos_x < cnt_x)
                    begin
                        cmd.act    = ACT_DELETE;
                        count_next = count_reg - 1'b1;
                    end
                    else
                    begin
                        st_pend_next = ST_RANGE;
                    end
                end
                default:
                begin
                    st_pend_next = ST_DONE;
                end
            endcase
        end
    end

    genvar g;
    generate
        for (g = 0; g < CAPACITY; g++)
        begin : g_cell
            logic [VAL_W-1:0] prev_e;
            logic [VAL_W-1:0] next_e;
            if (g == 0)
            begin : g_first
                assign prev_e = '0;
            end
            else
            begin : g_mid_lo
                assign prev_e = entry_w[g-1];
            end
            if (g == CAPACITY - 1)
            begin : g_last
                assign next_e = '0;
            end
            else
            begin : g_mid_hi
                assign next_e = entry_w[g+1];
            end
            isq_cell u_cell (
                .clk        (clk),
                .idx        (IDX_W'(g)),
                .cmd        (cmd),
                .prev_entry (prev_e),
                .next_entry (next_e),
                .entry      (entry_w[g]),
                .rd         (rd_w[g])
            );
        end
    endgenerate

    always_comb
    begin
        rd_all = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            rd_all = rd_all | rd_w[i];
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        out_valid_next  = out_valid_reg;
        read_value_next = read_value_reg;
        status_next     = status_reg;
        length_next     = length_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_GATHER;
                end
            end
            S_GATHER:
            begin
                read_value_next = rd_ok_reg ? rd_all : '1;
                status_next     = st_pend_reg;
                length_next     = LEN_W'(count_reg);
                out_valid_next  = 1'b1;
                state_next      = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        st_pend_reg    <= st_pend_next;
        rd_ok_reg      <= rd_ok_next;
        read_value_reg <= read_value_next;
        status_reg     <= status_next;
        length_reg     <= length_next;
    end

    assign out_valid  = out_valid_reg;
    assign read_value = read_value_reg;
    assign status     = status_reg;
    assign length     = length_reg;

endmodule

FILE: sv/isq_cell.sv
// ----------------------------------------------------------------------------
// Indexed sequence store cell
// Holds one entry of the sequence. On an insert at or below its index it takes
// its lower neighbour's entry or the new value, on a delete at or below it its
// upper neighbour's entry, and on a read it captures its entry when the position names it.
// ----------------------------------------------------------------------------
module isq_cell (
    input  logic                     clk,
    input  logic [isq_pkg::IDX_W-1:0] idx,
    input  isq_pkg::cell_cmd_t       cmd,
    input  logic [isq_pkg::VAL_W-1:0] prev_entry,
    input  logic [isq_pkg::VAL_W-1:0] next_entry,
    output logic [isq_pkg::VAL_W-1:0] entry,
    output logic [isq_pkg::VAL_W-1:0] rd
);
    import isq_pkg::*;

    logic [VAL_W-1:0] entry_reg;
    logic [VAL_W-1:0] entry_next;
    logic [VAL_W-1:0] rd_reg;
    logic [VAL_W-1:0] rd_next;

    always_comb
    begin
        entry_next = entry_reg;
        rd_next    = '0;
        case (cmd.act)
            ACT_INSERT:
            begin
                if (idx > cmd.pos)
                begin
                    entry_next = prev_entry;
                end
                else if (idx == cmd.pos)
                begin
                    entry_next = cmd.value;
                end
            end
            ACT_DELETE:
            begin
                if (idx >= cmd.pos)
                begin
                    entry_next = next_entry;
                end
            end
            ACT_READ:
            begin
                if (idx == cmd.pos)
                begin
                    rd_next = entry_reg;
                end
            end
            default:
            begin
                entry_next = entry_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
        rd_reg    <= rd_next;
    end

    assign entry = entry_reg;
    assign rd    = rd_reg;

endmodule
